// ----- sv/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// Connection cache table package
// Request, token and result types shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

	localparam int IDX_W = 8;
	localparam logic [31:0] TIMEOUT_RST = 32'd60;

	typedef enum logic [1:0] {
		FUNC_PUT    = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_EXPIRE = 2'd2,
		FUNC_DRAIN  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] now;
		logic [63:0] src;
		logic [63:0] dst;
		logic [15:0] hin;
		logic [31:0] timeout;
	} req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} fill_t;

	typedef struct packed {
		logic             vld;
		logic             done;
		logic [15:0]      handle;
		logic             have_old;
		logic [IDX_W-1:0] old_idx;
		logic [31:0]      old_time;
		logic [15:0]      old_handle;
		logic             nvalid;
		logic [31:0]      noldest;
	} token_t;

	typedef struct packed {
		logic        found;
		logic [15:0] handle;
		logic        nvalid;
		logic [31:0] noldest;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/connection_cache_table_core.sv -----
// ----------------------------------------------------------------------------
// Connection cache table core
// Table of cached connection entries with put, get, expire and drain requests.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the operation, tdata
// the time stamp, source key, destination key and handle. Each request
// yields one result on the m_axis channel: tuser carries found and
// next_valid, tdata the removed or evicted handle and the oldest remaining
// time stamp. The idle timeout is written on the cfg channel, which is
// always ready; a zero write is dropped.
// A request travels as a token along a row of ENTRIES cells, one cell per
// cycle; the token passes start_q and each cell's register, and its result
// is registered in the output register. One request is in the table at a
// time and the input reopens in the cycle the result appears, so a new
// request is taken only once the previous token has left the row. A put
// that evicts writes the chosen cell in the cycle the token leaves the row.
// Reset empties the table and sets the timeout to 60. When the receiver
// stalls, a finished result waits in the output register and the next
// request is still accepted; a second result waits in a skid register,
// and no further request is accepted until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_cache_table_core #(
	parameter int ENTRIES = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [175:0] s_axis_tdata,   // now_time, src_addr, dst_key, handle_in
	input  wire  [1:0]   s_axis_tuser,   // func
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [47:0]  m_axis_tdata,   // handle_out, next_oldest_time
	output logic [1:0]   m_axis_tuser,   // found, next_valid
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [31:0]  cfg_data
);
	import cct_pkg::*;

	logic [31:0] to_q;
	logic        busy_q;
	logic        start_q;
	func_t       func_q;
	logic [31:0] now_q;
	logic [63:0] src_q;
	logic [63:0] dst_q;
	logic [15:0] hin_q;
	logic        out_v_q;
	res_t        out_q;
	logic        skid_v_q;
	res_t        skid_q;

	req_t   req;
	fill_t  fill;
	token_t tok [ENTRIES+1];
	token_t tk;
	res_t   res;
	logic   accept;
	logic   arrive;
	logic   take;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy_q && !skid_v_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign take          = out_v_q && m_axis_tready;

	always_comb begin
		req.func    = func_q;
		req.now     = now_q;
		req.src     = src_q;
		req.dst     = dst_q;
		req.hin     = hin_q;
		req.timeout = to_q;
	end

	assign tok[0] = '{vld: start_q, default: '0};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cct_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req),
			.fill   (fill),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign tk     = tok[ENTRIES];
	assign arrive = tk.vld;

	always_comb begin
		fill.en  = arrive && func_q == FUNC_PUT && !tk.done;
		fill.idx = tk.old_idx;
		if (func_q == FUNC_PUT) begin
			res.found   = !tk.done;
			res.handle  = tk.done ? 16'd0 : tk.old_handle;
			res.nvalid  = 1'b0;
			res.noldest = 32'd0;
		end else begin
			res.found   = tk.done;
			res.handle  = tk.handle;
			res.nvalid  = tk.nvalid;
			res.noldest = tk.noldest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_q     <= TIMEOUT_RST;
			busy_q   <= 1'b0;
			start_q  <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_data != 32'd0) begin
				to_q <= cfg_data;
			end
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (arrive) begin
				busy_q <= 1'b0;
			end
			if (arrive) begin
				if (out_v_q && !take) begin
					skid_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(s_axis_tuser);
			now_q  <= s_axis_tdata[31:0];
			src_q  <= s_axis_tdata[95:32];
			dst_q  <= s_axis_tdata[159:96];
			hin_q  <= s_axis_tdata[175:160];
		end
		if (arrive) begin
			if (out_v_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = {out_q.nvalid, out_q.found};
	assign m_axis_tdata  = {out_q.noldest, out_q.handle};

	a_arrive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arrive |-> busy_q)
		else $error("token left the row with no request in flight");

	a_arrive_latency: assert property (@(posedge clk) disable iff (!arst_n)
		arrive |-> $past(start_q, ENTRIES))
		else $error("token latency through the row is wrong");

	a_skid_free: assert property (@(posedge clk) disable iff (!arst_n)
		arrive |-> !skid_v_q)
		else $error("result arrived while the skid register was full");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result ahead of an empty output");

endmodule

`default_nettype wire

// ----- sv/cct_cell.sv -----
// ----------------------------------------------------------------------------
// Connection cache table cell
// Holds one table entry and updates the request token as it passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_cell #(
	parameter int IDX = 0
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire cct_pkg::req_t   req,
	input  wire cct_pkg::fill_t  fill,
	input  wire cct_pkg::token_t tok_in,
	output cct_pkg::token_t tok_out
);
	import cct_pkg::*;

	logic        valid_q;
	logic [31:0] time_q;
	logic [15:0] handle_q;
	logic [63:0] src_q;
	logic [63:0] dst_q;
	token_t      tok_q;

	token_t tok_nx;
	logic   do_fill;
	logic   do_clear;
	logic   commit;
	logic   idle;

	assign idle   = ({1'b0, time_q} + {1'b0, req.timeout}) <= {1'b0, req.now};
	assign commit = fill.en && (fill.idx == IDX_W'(IDX));

	always_comb begin
		tok_nx   = tok_in;
		do_fill  = 1'b0;
		do_clear = 1'b0;
		if (tok_in.vld) begin
			case (req.func)
				FUNC_PUT: begin
					if (!tok_in.done) begin
						if (!valid_q) begin
							do_fill     = 1'b1;
							tok_nx.done = 1'b1;
						end else if (!tok_in.have_old || time_q < tok_in.old_time) begin
							tok_nx.have_old   = 1'b1;
							tok_nx.old_idx    = IDX_W'(IDX);
							tok_nx.old_time   = time_q;
							tok_nx.old_handle = handle_q;
						end
					end
				end
				FUNC_GET: begin
					if (!tok_in.done && valid_q && src_q == req.src && dst_q == req.dst) begin
						do_clear      = 1'b1;
						tok_nx.done   = 1'b1;
						tok_nx.handle = handle_q;
					end
				end
				default: begin
					if (valid_q) begin
						if (!tok_in.done && (req.func == FUNC_DRAIN || idle)) begin
							do_clear      = 1'b1;
							tok_nx.done   = 1'b1;
							tok_nx.handle = handle_q;
						end else if (!tok_in.nvalid || time_q < tok_in.noldest) begin
							tok_nx.nvalid  = 1'b1;
							tok_nx.noldest = time_q;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nx;
			if (do_fill || commit) begin
				valid_q <= 1'b1;
			end else if (do_clear) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_fill || commit) begin
			time_q   <= req.now;
			handle_q <= req.hin;
			src_q    <= req.src;
			dst_q    <= req.dst;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Connection cache table core testbench
// Sends put, get, expire and drain requests with bursty timing against a
// stalling receiver, keeps a shadow copy of the table and checks each result.
// ----------------------------------------------------------------------------

module tb;

	import cct_pkg::*;

	localparam int          ENTRIES     = 16;
	localparam int          KEY_POOL    = 32;
	localparam int          LONG_HOLD   = 300;
	localparam int          RX_WINDOW   = 512;
	localparam longint      CYCLE_LIMIT = 1000000;
	localparam logic [63:0] ONES64      = '1;

	typedef struct packed {
		func_t       func;
		logic [31:0] now;
		logic [63:0] src;
		logic [63:0] dst;
		logic [15:0] hin;
	} conn_req_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata  = '0;   // now_time, src_addr, dst_key, handle_in
	logic [1:0]   s_axis_tuser  = '0;   // func
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;         // handle_out, next_oldest_time
	logic [1:0]   m_axis_tuser;         // found, next_valid
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data      = '0;

	conn_req_t req_backlog[$];
	res_t      due_results[$];
	conn_req_t cur_req;

	logic        tbl_live   [ENTRIES];
	logic [31:0] tbl_stamp  [ENTRIES];
	logic [15:0] tbl_handle [ENTRIES];
	logic [63:0] tbl_src    [ENTRIES];
	logic [63:0] tbl_dst    [ENTRIES];
	logic [31:0] idle_limit = TIMEOUT_RST;

	logic [63:0] pool_src [KEY_POOL];
	logic [63:0] pool_dst [KEY_POOL];
	logic [31:0] gen_now;

	int     queued_cnt   = 0;
	int     accepted_cnt = 0;
	int     checked_cnt  = 0;
	int     mismatches   = 0;
	int     evict_cnt    = 0;
	int     get_hit_cnt  = 0;
	int     expire_hit   = 0;
	int     drain_hit    = 0;
	int     burst_left   = 0;
	int     gap_left     = 0;
	int     rx_cnt       = 0;
	longint cycle_cnt    = 0;

	connection_cache_table_core #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t cache_lookup_result(conn_req_t r);
		res_t        o;
		int          slot;
		int          oldest;
		logic        take;
		logic [32:0] due;
		o = '0;
		case (r.func)
			FUNC_PUT: begin
				slot   = -1;
				oldest = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot < 0) begin
						if (!tbl_live[i])
							slot = i;
						else if (oldest < 0 || tbl_stamp[i] < tbl_stamp[oldest])
							oldest = i;
					end
				end
				if (slot < 0) begin
					o.found  = 1'b1;
					o.handle = tbl_handle[oldest];
					slot     = oldest;
					evict_cnt++;
				end
				tbl_live[slot]   = 1'b1;
				tbl_stamp[slot]  = r.now;
				tbl_src[slot]    = r.src;
				tbl_dst[slot]    = r.dst;
				tbl_handle[slot] = r.hin;
			end
			FUNC_GET: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!o.found && tbl_live[i] && tbl_dst[i] == r.dst && tbl_src[i] == r.src) begin
						o.found     = 1'b1;
						o.handle    = tbl_handle[i];
						tbl_live[i] = 1'b0;
						get_hit_cnt++;
					end
				end
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_live[i]) begin
						due  = {1'b0, tbl_stamp[i]} + {1'b0, idle_limit};
						take = (r.func == FUNC_DRAIN) || (due <= {1'b0, r.now});
						if (!o.found && take) begin
							o.found     = 1'b1;
							o.handle    = tbl_handle[i];
							tbl_live[i] = 1'b0;
							if (r.func == FUNC_DRAIN)
								drain_hit++;
							else
								expire_hit++;
						end else if (!o.nvalid || tbl_stamp[i] < o.noldest) begin
							o.nvalid  = 1'b1;
							o.noldest = tbl_stamp[i];
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	function automatic void compare_field(string what, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// driver: bursts of requests with random gaps, prediction at acceptance
	always @(posedge clk) begin
		logic go;
		if (arst_n) begin
			go = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(cache_lookup_result(cur_req));
				accepted_cnt++;
				go = 1'b0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_backlog.size() > 0) begin
					cur_req      = req_backlog.pop_front();
					s_axis_tdata <= {cur_req.hin, cur_req.dst, cur_req.src, cur_req.now};
					s_axis_tuser <= cur_req.func;
					go = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 7);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
			s_axis_tvalid <= go;
		end
	end

	// receiver: always ready, random, fixed pattern, then a long hold-off
	always @(posedge clk) begin
		int mode;
		int pos;
		rx_cnt++;
		mode = (rx_cnt / RX_WINDOW) % 4;
		pos  = rx_cnt % RX_WINDOW;
		case (mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= (pos % 5) != 0;
			default: m_axis_tready <= pos >= LONG_HOLD;
		endcase
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.found   = m_axis_tuser[0];
			got.nvalid  = m_axis_tuser[1];
			got.handle  = m_axis_tdata[15:0];
			got.noldest = m_axis_tdata[47:16];
			if (due_results.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0h", $time, got);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				compare_field("found", 64'(want.found), 64'(got.found));
				compare_field("handle_out", 64'(want.handle), 64'(got.handle));
				compare_field("next_valid", 64'(want.nvalid), 64'(got.nvalid));
				compare_field("next_oldest_time", 64'(want.noldest), 64'(got.noldest));
				checked_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, due_results.size());
			$display("tb: errors");
			$finish;
		end
	end

	task automatic queue_req(func_t f, logic [31:0] now, logic [63:0] src,
			logic [63:0] dst, logic [15:0] hin);
		conn_req_t r;
		r.func = f;
		r.now  = now;
		r.src  = src;
		r.dst  = dst;
		r.hin  = hin;
		req_backlog.push_back(r);
		queued_cnt++;
	endtask

	task automatic queue_random(int n);
		func_t       f;
		logic [31:0] now;
		logic [63:0] src;
		logic [63:0] dst;
		int          k;
		int          pick;
		for (int j = 0; j < n; j++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				f = FUNC_PUT;
			else if (pick < 75)
				f = FUNC_GET;
			else if (pick < 90)
				f = FUNC_EXPIRE;
			else
				f = FUNC_DRAIN;
			case ($urandom_range(0, 15))
				0:       now = '0;
				1:       now = '1;
				2:       now = $urandom;
				default: begin
					gen_now += $urandom_range(0, 6);
					now = gen_now;
				end
			endcase
			k = $urandom_range(0, KEY_POOL - 1);
			if (f == FUNC_PUT && $urandom_range(0, 7) == 0) begin
				pool_src[k] = {$urandom, $urandom};
				pool_dst[k] = {$urandom, $urandom};
			end
			src = pool_src[k];
			dst = pool_dst[k];
			if (f == FUNC_GET) begin
				case ($urandom_range(0, 7))
					0:       src = src ^ (64'd1 << $urandom_range(0, 63));
					1:       begin
						src = {$urandom, $urandom};
						dst = {$urandom, $urandom};
					end
					default: ;
				endcase
			end
			queue_req(f, now, src, dst, 16'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || due_results.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 6) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v != 32'd0)
			idle_limit = v;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			tbl_live[i] = 1'b0;
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_src[i] = {$urandom, $urandom};
			pool_dst[i] = {$urandom, $urandom};
		end
		gen_now = $urandom_range(0, 1000);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_req(FUNC_GET, '0, '0, '0, '0);
		queue_req(FUNC_EXPIRE, '1, '0, '0, '0);
		queue_req(FUNC_DRAIN, '0, '0, '0, '0);
		queue_req(FUNC_PUT, '0, '0, '0, '0);
		queue_req(FUNC_PUT, '1, ONES64, ONES64, 16'hFFFF);
		queue_req(FUNC_GET, '0, ONES64 ^ 64'd1, ONES64, '0);
		queue_req(FUNC_GET, '0, ONES64, ONES64, '0);
		for (int i = 1; i < ENTRIES; i++)
			queue_req(FUNC_PUT, 32'd5, 64'(i), 64'(i) << 32, 16'(i + 1));
		queue_req(FUNC_PUT, 32'd7, 64'hA5A5, 64'h5A5A, 16'h1234);
		queue_req(FUNC_PUT, 32'd9, 64'hC3C3, 64'h3C3C, 16'h4321);
		queue_req(FUNC_EXPIRE, 32'd65, '0, '0, '0);
		queue_req(FUNC_EXPIRE, 32'd3, '0, '0, '0);
		queue_req(FUNC_DRAIN, '0, '0, '0, '0);
		wait_idle();

		write_timeout(32'd1);
		queue_random(300);
		wait_idle();
		write_timeout(32'd0);
		queue_random(100);
		wait_idle();
		write_timeout(32'hFFFF_FFFF);
		queue_random(300);
		wait_idle();
		write_timeout($urandom_range(2, 200));
		queue_random(300);
		wait_idle();
		write_timeout(TIMEOUT_RST);
		queue_random(200);
		wait_idle();

		$display("tb: %0d requests checked over five timeout settings", checked_cnt);
		$display("tb: %0d evictions, %0d get hits, %0d expiries, %0d drains, %0d mismatches",
			evict_cnt, get_hit_cnt, expire_hit, drain_hit, mismatches);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
